// ===== rtl/core/cmm_pkg.sv =====
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types, constants and codes of the color match mask pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cmm_pkg;

    // Channel and mask widths
    localparam int CH_W   = 16;
    localparam int MASK_W = 16;
    localparam logic [CH_W-1:0]   CH_FS     = {CH_W{1'b1}};
    localparam logic [MASK_W-1:0] MASK_FULL = {MASK_W{1'b1}};

    // Divider: quotient bits resolved per pipeline stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = MASK_W / DIV_BITS;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_REF_C0    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REF_C1    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REF_C2    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REF_ALPHA = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CRITERION = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OPTIONS   = 3'd7;

    // Criterion codes
    localparam logic [2:0] CRIT_COMPOSITE = 3'd0;
    localparam logic [2:0] CRIT_RED       = 3'd1;
    localparam logic [2:0] CRIT_GREEN     = 3'd2;
    localparam logic [2:0] CRIT_BLUE      = 3'd3;
    localparam logic [2:0] CRIT_HUE       = 3'd4;
    localparam logic [2:0] CRIT_SAT       = 3'd5;
    localparam logic [2:0] CRIT_VAL       = 3'd6;

    // Option flag bit positions
    localparam int OPT_ANTIALIAS = 0;
    localparam int OPT_TRANSP    = 1;
    localparam int OPT_HAS_ALPHA = 2;

    // Result class decided before the divider
    typedef logic [1:0] t_cls;
    localparam t_cls CLS_ZERO = 2'd0;
    localparam t_cls CLS_FULL = 2'd1;
    localparam t_cls CLS_RAMP = 2'd2;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [CH_W-1:0] ref_c0;
        logic [CH_W-1:0] ref_c1;
        logic [CH_W-1:0] ref_c2;
        logic [CH_W-1:0] ref_alpha;
        logic [CH_W-1:0] threshold;
        logic [2:0]      criterion;
        logic [1:0]      channels;
        logic [2:0]      options;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/color_match_mask.sv =====
// ----------------------------------------------------------------------------
// color_match_mask
// Per-pixel color distance threshold mask, one pixel per unstalled clock.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle while o_stall is low and returns one 16-bit mask
// value per pixel, in order: the pixel passes nine register stages, the first
// of which captures it at the accepting edge. Three stages form and classify
// the distance, five stages run the pipelined ramp divider (one loads the
// scaled numerator, four resolve four quotient bits each), and one output
// register drives the result. Every stage carries its own valid bit, so empty
// slots fill up while the output is stalled and a full pipeline sustains one
// pixel per clock while the output is not stalled.
// Configuration registers are written through the cfg port, which is always
// ready; write them only while no pixel is in flight.
`default_nettype none

module color_match_mask (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cmm_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cmm_pkg::CH_W-1:0]       i_cfg_wdata,
    // pixel request channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [cmm_pkg::CH_W-1:0]       i_pix_c0,
    input  wire logic [cmm_pkg::CH_W-1:0]       i_pix_c1,
    input  wire logic [cmm_pkg::CH_W-1:0]       i_pix_c2,
    input  wire logic [cmm_pkg::CH_W-1:0]       i_pix_alpha,
    // mask result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [cmm_pkg::MASK_W-1:0]          o_mask_value
);

    cmm_pkg::t_cfg             cfg;
    logic                      dist_load, dist_valid;
    cmm_pkg::t_cls             dist_cls;
    logic [cmm_pkg::CH_W-1:0]  dist_rem;
    logic                      div_load, div_valid;
    cmm_pkg::t_cls             div_cls;
    logic [cmm_pkg::MASK_W-1:0] div_quot;
    logic                      out_load;
    logic                      r_out_v;
    logic [cmm_pkg::MASK_W-1:0] r_out_mask;
    logic [cmm_pkg::MASK_W-1:0] n_out_mask;

    cmm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cmm_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_load      (dist_load),
        .i_pix_c0    (i_pix_c0),
        .i_pix_c1    (i_pix_c1),
        .i_pix_c2    (i_pix_c2),
        .i_pix_alpha (i_pix_alpha),
        .i_next_load (div_load),
        .o_valid     (dist_valid),
        .o_cls       (dist_cls),
        .o_rem       (dist_rem)
    );

    cmm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (cfg.threshold),
        .i_valid     (dist_valid),
        .o_load      (div_load),
        .i_cls       (dist_cls),
        .i_rem       (dist_rem),
        .i_next_load (out_load),
        .o_valid     (div_valid),
        .o_cls       (div_cls),
        .o_quot      (div_quot)
    );

    // Stall the pixel request when the first stage cannot advance
    assign o_stall  = !dist_load;
    assign out_load = !r_out_v || !i_stall;

    // Resolve the final mask from its class
    always_comb begin
        case (div_cls)
            cmm_pkg::CLS_FULL: n_out_mask = cmm_pkg::MASK_FULL;
            cmm_pkg::CLS_RAMP: n_out_mask = div_quot;
            default:           n_out_mask = '0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mask <= n_out_mask;
        end
    end

    assign o_valid      = r_out_v;
    assign o_mask_value = r_out_mask;

    // An empty output register never blocks the pixel input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> !o_stall)
        else $error("input stalled with empty output register");

    // A result leaving while the divider's last stage holds an item is replaced next cycle
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_stall && div_valid) |=> r_out_v)
        else $error("output register not refilled");

endmodule

`default_nettype wire

// ===== rtl/core/cmm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cmm_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cmm_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cmm_pkg::CH_W-1:0]       i_cfg_wdata,
    output cmm_pkg::t_cfg                       o_cfg
);

    cmm_pkg::t_cfg r_cfg;

    // Always able to take a write request
    assign o_cfg_ready = 1'b1;

    // Decode the index and store the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_c0    <= '0;
            r_cfg.ref_c1    <= '0;
            r_cfg.ref_c2    <= '0;
            r_cfg.ref_alpha <= cmm_pkg::CH_FS;
            r_cfg.threshold <= '0;
            r_cfg.criterion <= cmm_pkg::CRIT_COMPOSITE;
            r_cfg.channels  <= 2'd3;
            r_cfg.options   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cmm_pkg::REG_REF_C0:    r_cfg.ref_c0    <= i_cfg_wdata;
                cmm_pkg::REG_REF_C1:    r_cfg.ref_c1    <= i_cfg_wdata;
                cmm_pkg::REG_REF_C2:    r_cfg.ref_c2    <= i_cfg_wdata;
                cmm_pkg::REG_REF_ALPHA: r_cfg.ref_alpha <= i_cfg_wdata;
                cmm_pkg::REG_THRESHOLD: r_cfg.threshold <= i_cfg_wdata;
                cmm_pkg::REG_CRITERION: r_cfg.criterion <= i_cfg_wdata[2:0];
                cmm_pkg::REG_CHANNELS:  r_cfg.channels  <= i_cfg_wdata[1:0];
                cmm_pkg::REG_OPTIONS:   r_cfg.options   <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/cmm_dist.sv =====
// ----------------------------------------------------------------------------
// cmm_dist
// Three-stage front end: channel differences, distance select, and
// classification of the distance against the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_dist (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cmm_pkg::t_cfg              i_cfg,
    input  wire logic                       i_valid,
    output logic                            o_load,
    input  wire logic [cmm_pkg::CH_W-1:0]   i_pix_c0,
    input  wire logic [cmm_pkg::CH_W-1:0]   i_pix_c1,
    input  wire logic [cmm_pkg::CH_W-1:0]   i_pix_c2,
    input  wire logic [cmm_pkg::CH_W-1:0]   i_pix_alpha,
    input  wire logic                       i_next_load,
    output logic                            o_valid,
    output cmm_pkg::t_cls                   o_cls,
    output logic [cmm_pkg::CH_W-1:0]        o_rem
);

    // Stage A: absolute differences
    logic                     r_a_v;
    logic [cmm_pkg::CH_W-1:0] r_a_d0, r_a_d1, r_a_d2, r_a_da;
    logic                     r_a_pa_zero;
    // Stage B: selected distance
    logic                     r_b_v;
    logic [cmm_pkg::CH_W-1:0] r_b_d;
    logic                     r_b_kill;
    // Stage C: class and ramp numerator
    logic                     r_c_v;
    cmm_pkg::t_cls            r_c_cls;
    logic [cmm_pkg::CH_W-1:0] r_c_rem;

    logic load_a, load_b, load_c;

    logic [cmm_pkg::CH_W-1:0] n_a_d0, n_a_d1, n_a_d2, n_a_da;
    logic [cmm_pkg::CH_W-1:0] n_b_d;
    logic                     n_b_kill;
    logic                     transp, alpha_used;
    cmm_pkg::t_cls            n_c_cls;
    logic [cmm_pkg::CH_W-1:0] n_c_rem;
    logic [cmm_pkg::CH_W+1:0] t3, d2x, ramp_num;
    logic                     aa_on;

    // Advance a stage when it is empty or the stage after it advances
    assign load_c = !r_c_v || i_next_load;
    assign load_b = !r_b_v || load_c;
    assign load_a = !r_a_v || load_b;
    assign o_load = load_a;

    // Stage A logic: unsigned differences
    always_comb begin
        n_a_d0 = (i_cfg.ref_c0 > i_pix_c0) ? i_cfg.ref_c0 - i_pix_c0
                                           : i_pix_c0 - i_cfg.ref_c0;
        n_a_d1 = (i_cfg.ref_c1 > i_pix_c1) ? i_cfg.ref_c1 - i_pix_c1
                                           : i_pix_c1 - i_cfg.ref_c1;
        n_a_d2 = (i_cfg.ref_c2 > i_pix_c2) ? i_cfg.ref_c2 - i_pix_c2
                                           : i_pix_c2 - i_cfg.ref_c2;
        n_a_da = (i_cfg.ref_alpha > i_pix_alpha) ? i_cfg.ref_alpha - i_pix_alpha
                                                 : i_pix_alpha - i_cfg.ref_alpha;
    end

    // Stage B logic: pick the distance for the active criterion
    assign alpha_used = i_cfg.options[cmm_pkg::OPT_HAS_ALPHA];
    assign transp     = alpha_used && i_cfg.options[cmm_pkg::OPT_TRANSP]
                        && (i_cfg.ref_alpha == '0);

    always_comb begin
        n_b_d    = '0;
        n_b_kill = !transp && alpha_used && r_a_pa_zero;
        if (transp) begin
            n_b_d = r_a_da;
        end else begin
            unique case (i_cfg.criterion) inside
                cmm_pkg::CRIT_RED:                    n_b_d = r_a_d0;
                cmm_pkg::CRIT_GREEN, cmm_pkg::CRIT_SAT: n_b_d = r_a_d1;
                cmm_pkg::CRIT_BLUE, cmm_pkg::CRIT_VAL:  n_b_d = r_a_d2;
                cmm_pkg::CRIT_HUE: begin
                    // wrap around: the shorter way round the hue circle
                    n_b_d = (r_a_d0 < (cmm_pkg::CH_FS - r_a_d0))
                            ? r_a_d0 : cmm_pkg::CH_FS - r_a_d0;
                end
                default: begin
                    // composite: largest difference over the used channels
                    if (i_cfg.channels >= 2'd1) n_b_d = r_a_d0;
                    if (i_cfg.channels >= 2'd2 && r_a_d1 > n_b_d) n_b_d = r_a_d1;
                    if (i_cfg.channels >= 2'd3 && r_a_d2 > n_b_d) n_b_d = r_a_d2;
                end
            endcase
        end
    end

    // Stage C logic: hard test or ramp region
    assign aa_on    = i_cfg.options[cmm_pkg::OPT_ANTIALIAS];
    assign t3       = {2'b00, i_cfg.threshold} + {1'b0, i_cfg.threshold, 1'b0};
    assign d2x      = {1'b0, r_b_d, 1'b0};
    assign ramp_num = t3 - d2x;

    always_comb begin
        n_c_rem = ramp_num[cmm_pkg::CH_W-1:0];
        if (r_b_kill) begin
            n_c_cls = cmm_pkg::CLS_ZERO;
        end else if (!aa_on || i_cfg.threshold == '0) begin
            n_c_cls = (r_b_d > i_cfg.threshold) ? cmm_pkg::CLS_ZERO : cmm_pkg::CLS_FULL;
        end else if (r_b_d <= i_cfg.threshold) begin
            n_c_cls = cmm_pkg::CLS_FULL;
        end else if (d2x >= t3) begin
            n_c_cls = cmm_pkg::CLS_ZERO;
        end else begin
            n_c_cls = cmm_pkg::CLS_RAMP;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (load_a) r_a_v <= i_valid;
            if (load_b) r_b_v <= r_a_v;
            if (load_c) r_c_v <= r_b_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_d0      <= n_a_d0;
            r_a_d1      <= n_a_d1;
            r_a_d2      <= n_a_d2;
            r_a_da      <= n_a_da;
            r_a_pa_zero <= (i_pix_alpha == '0);
        end
        if (load_b) begin
            r_b_d    <= n_b_d;
            r_b_kill <= n_b_kill;
        end
        if (load_c) begin
            r_c_cls <= n_c_cls;
            r_c_rem <= n_c_rem;
        end
    end

    assign o_valid = r_c_v;
    assign o_cls   = r_c_cls;
    assign o_rem   = r_c_rem;

endmodule

`default_nettype wire

// ===== rtl/core/cmm_div.sv =====
// ----------------------------------------------------------------------------
// cmm_div
// Pipelined restoring divider for the antialias ramp: computes
// floor(rem * 65535 / threshold), four quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [cmm_pkg::CH_W-1:0]   i_threshold,
    input  wire logic                       i_valid,
    output logic                            o_load,
    input  wire cmm_pkg::t_cls              i_cls,
    input  wire logic [cmm_pkg::CH_W-1:0]   i_rem,
    input  wire logic                       i_next_load,
    output logic                            o_valid,
    output cmm_pkg::t_cls                   o_cls,
    output logic [cmm_pkg::MASK_W-1:0]      o_quot
);

    localparam int NS = cmm_pkg::DIV_STAGES;

    // Stage 0 holds the scaled numerator, stages 1..NS the division steps
    logic                        r_v   [0:NS];
    cmm_pkg::t_cls               r_cls [0:NS];
    logic [cmm_pkg::CH_W-1:0]    r_hi  [0:NS];
    logic [cmm_pkg::MASK_W-1:0]  r_lo  [0:NS];
    logic [cmm_pkg::MASK_W-1:0]  r_q   [0:NS];
    logic                        load  [0:NS+1];

    logic [cmm_pkg::CH_W+cmm_pkg::MASK_W-1:0] num;

    // Scale by full mask: rem * (2^16 - 1)
    assign num = {i_rem, {cmm_pkg::MASK_W{1'b0}}}
               - {{cmm_pkg::MASK_W{1'b0}}, i_rem};

    assign load[NS+1] = i_next_load;

    genvar g;
    generate
        for (g = 0; g <= NS; g++) begin : g_load
            assign load[g] = !r_v[g] || load[g+1];
        end
    endgenerate

    assign o_load = load[0];

    // Stage 0: register the numerator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (load[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_cls[0] <= i_cls;
            r_hi[0]  <= num[cmm_pkg::CH_W+cmm_pkg::MASK_W-1:cmm_pkg::MASK_W];
            r_lo[0]  <= num[cmm_pkg::MASK_W-1:0];
            r_q[0]   <= '0;
        end
    end

    // Division stages, DIV_BITS steps each: shift in one numerator bit, subtract when it fits
    generate
        for (g = 1; g <= NS; g++) begin : g_stage
            logic [cmm_pkg::CH_W-1:0]   n_hi;
            logic [cmm_pkg::MASK_W-1:0] n_lo;
            logic [cmm_pkg::MASK_W-1:0] n_q;

            always_comb begin
                logic [cmm_pkg::CH_W:0] part;
                logic [cmm_pkg::CH_W:0] diff;
                n_hi = r_hi[g-1];
                n_lo = r_lo[g-1];
                n_q  = r_q[g-1];
                for (int j = 0; j < cmm_pkg::DIV_BITS; j++) begin
                    part = {n_hi, n_lo[cmm_pkg::MASK_W-1]};
                    diff = part - {1'b0, i_threshold};
                    n_lo = {n_lo[cmm_pkg::MASK_W-2:0], 1'b0};
                    if (part >= {1'b0, i_threshold}) begin
                        n_hi = diff[cmm_pkg::CH_W-1:0];
                        n_q  = {n_q[cmm_pkg::MASK_W-2:0], 1'b1};
                    end else begin
                        n_hi = part[cmm_pkg::CH_W-1:0];
                        n_q  = {n_q[cmm_pkg::MASK_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (load[g]) begin
                    r_v[g] <= r_v[g-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (load[g]) begin
                    r_cls[g] <= r_cls[g-1];
                    r_hi[g]  <= n_hi;
                    r_lo[g]  <= n_lo;
                    r_q[g]   <= n_q;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NS];
    assign o_cls   = r_cls[NS];
    assign o_quot  = r_q[NS];

    // Ramp results stay below full scale
    a_ramp_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS] && r_cls[NS] == cmm_pkg::CLS_RAMP) |-> (r_q[NS] != cmm_pkg::MASK_FULL))
        else $error("ramp quotient reached full scale");

    // Partial remainder stays below the divisor on the ramp path
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS] && r_cls[NS] == cmm_pkg::CLS_RAMP) |-> (r_hi[NS] < i_threshold))
        else $error("divider remainder not below threshold");

    // A held last stage keeps its item
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS] && !i_next_load) |=> (r_v[NS] && $stable(r_q[NS]) && $stable(r_cls[NS])))
        else $error("divider dropped a held item");

endmodule

`default_nettype wire

// ===== tb/color_match_mask_test.sv =====
// ----------------------------------------------------------------------------
// color_match_mask_test
// Self-checking testbench for the color match mask pipeline.
// ----------------------------------------------------------------------------
// Drives pixel requests with random bursts and gaps, stalls the mask output
// on a pattern of its own, and compares every mask value with a predictor of
// the distance and threshold logic. Directed tests cover the reset setup,
// every criterion, hue wrap-around, the alpha cases and the antialias ramp.
// A long output hold-off fills the pipeline. Random setups with pixels near
// the reference and the threshold finish the run.
// ----------------------------------------------------------------------------

module color_match_mask_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cmm_pkg::*;

    localparam int         CYCLE_LIMIT    = 300000;
    localparam int         SETTLE_CYCLES  = 12;
    localparam int         HOLDOFF_CYCLES = 300;
    localparam int         RANDOM_SETUPS  = 15;
    localparam int         PIXELS_PER_SETUP = 90;
    localparam logic [2:0] CRIT_UNUSED    = 3'd7;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_pattern;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [REG_IDX_W-1:0]  i_cfg_index;
    logic [CH_W-1:0]       i_cfg_wdata;
    logic                  i_valid;
    logic                  o_stall;
    logic [CH_W-1:0]       i_pix_c0;
    logic [CH_W-1:0]       i_pix_c1;
    logic [CH_W-1:0]       i_pix_c2;
    logic [CH_W-1:0]       i_pix_alpha;
    logic                  o_valid;
    logic                  i_stall;
    logic [MASK_W-1:0]     o_mask_value;

    // Predictor state and expected masks
    t_cfg                  cfg_model;
    logic [MASK_W-1:0]     mask_expected_q[$];
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;

    // Sender pacing and receiver hold-off control
    bit                    sender_steady = 1'b0;
    int                    burst_left    = 0;
    bit                    holdoff_req   = 1'b0;

    color_match_mask i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pix_c0     (i_pix_c0),
        .i_pix_c1     (i_pix_c1),
        .i_pix_c2     (i_pix_c2),
        .i_pix_alpha  (i_pix_alpha),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mask_value (o_mask_value)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // End the run at a generous cycle limit
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d masks outstanding",
                         cycle_count, mask_expected_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [CH_W-1:0] chan_distance(input logic [CH_W-1:0] a,
                                                      input logic [CH_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [MASK_W-1:0] predict_mask(input t_cfg cfg,
                                                       input logic [CH_W-1:0] p0,
                                                       input logic [CH_W-1:0] p1,
                                                       input logic [CH_W-1:0] p2,
                                                       input logic [CH_W-1:0] pa);
        logic            antialias;
        logic            alpha_used;
        logic            transparent;
        logic [CH_W-1:0] pix_dist;
        logic [CH_W-1:0] d0;
        logic [CH_W-1:0] d1;
        logic [CH_W-1:0] d2;
        longint unsigned thr3;
        longint unsigned dist2;
        antialias   = cfg.options[OPT_ANTIALIAS];
        alpha_used  = cfg.options[OPT_HAS_ALPHA];
        transparent = alpha_used && cfg.options[OPT_TRANSP] && (cfg.ref_alpha == '0);

        // Drop fully transparent pixels unless transparent selection is on
        if (!transparent && alpha_used && pa == '0)
            return '0;

        d0 = chan_distance(cfg.ref_c0, p0);
        d1 = chan_distance(cfg.ref_c1, p1);
        d2 = chan_distance(cfg.ref_c2, p2);
        pix_dist = '0;
        if (transparent) begin
            pix_dist = chan_distance(cfg.ref_alpha, pa);
        end else begin
            case (cfg.criterion)
                CRIT_RED:             pix_dist = d0;
                CRIT_GREEN, CRIT_SAT: pix_dist = d1;
                CRIT_BLUE, CRIT_VAL:  pix_dist = d2;
                CRIT_HUE:             pix_dist = (d0 < CH_FS - d0) ? d0 : CH_FS - d0;
                default: begin
                    // Composite: largest difference over the compared channels
                    if (cfg.channels >= 2'd1) pix_dist = d0;
                    if (cfg.channels >= 2'd2 && d1 > pix_dist) pix_dist = d1;
                    if (cfg.channels >= 2'd3 && d2 > pix_dist) pix_dist = d2;
                end
            endcase
        end

        // Hard test, or the ramp between 1.0 and 1.5 times the threshold
        if (antialias && cfg.threshold != '0) begin
            thr3  = 3 * longint'(cfg.threshold);
            dist2 = 2 * longint'(pix_dist);
            if (pix_dist <= cfg.threshold)
                return MASK_FULL;
            if (dist2 >= thr3)
                return '0;
            return MASK_W'(((thr3 - dist2) * MASK_FULL) / cfg.threshold);
        end
        return (pix_dist > cfg.threshold) ? '0 : MASK_FULL;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (mask_expected_q.size() == 0) begin
                $error("mask_value with no request outstanding: actual %h",
                       o_mask_value);
                mismatch_count++;
            end else if (o_mask_value !== mask_expected_q[0]) begin
                $error("mask_value mismatch: expected %h, actual %h",
                       mask_expected_q[0], o_mask_value);
                mismatch_count++;
                void'(mask_expected_q.pop_front());
            end else begin
                void'(mask_expected_q.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stall pattern, with a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : rx_stall_gen
        bit          holdoff_seen;
        int          holdoff_left;
        int          pattern_left;
        int          pattern_step;
        t_rx_pattern pattern;
        holdoff_seen = 1'b0;
        holdoff_left = 0;
        pattern_left = 0;
        pattern_step = 0;
        pattern      = RX_OPEN;
        i_stall      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req != holdoff_seen) begin
                holdoff_seen = holdoff_req;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_stall <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = t_rx_pattern'($urandom_range(0, 3));
                    pattern_left = $urandom_range(32, 400);
                end
                pattern_left--;
                pattern_step++;
                case (pattern)
                    RX_OPEN:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 7) == 0);
                    RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:  i_stall <= ((pattern_step % 5) < 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------
    // Write one register and mirror it in the predictor configuration
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CH_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_REF_C0:    cfg_model.ref_c0    = data;
            REG_REF_C1:    cfg_model.ref_c1    = data;
            REG_REF_C2:    cfg_model.ref_c2    = data;
            REG_REF_ALPHA: cfg_model.ref_alpha = data;
            REG_THRESHOLD: cfg_model.threshold = data;
            REG_CRITERION: cfg_model.criterion = data[2:0];
            REG_CHANNELS:  cfg_model.channels  = data[1:0];
            default:       cfg_model.options   = data[2:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one pixel request, hold it until accepted, then pace the sender
    task automatic send_pixel(input logic [CH_W-1:0] c0, input logic [CH_W-1:0] c1,
                              input logic [CH_W-1:0] c2, input logic [CH_W-1:0] alpha);
        int gap;
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_pix_c0    <= c0;
        i_pix_c1    <= c1;
        i_pix_c2    <= c2;
        i_pix_alpha <= alpha;
        do @(posedge i_clk); while (o_stall);
        mask_expected_q.push_back(predict_mask(cfg_model, c0, c1, c2, alpha));
        if (!sender_steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(0, 12);
                repeat (gap) @(negedge i_clk) i_valid <= 1'b0;
            end
        end
    endtask

    // Drop valid and wait until every expected mask has come out
    task automatic wait_mask_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (mask_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset setup: composite over three channels, zero threshold, no alpha
    task automatic test_reset_defaults();
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        wait_mask_drain();
    endtask

    // Every criterion, the unused code, and a composite over no channels
    task automatic test_criteria();
        logic [2:0] crit_list[8];
        crit_list = '{CRIT_COMPOSITE, CRIT_RED, CRIT_GREEN, CRIT_BLUE,
                      CRIT_HUE, CRIT_SAT, CRIT_VAL, CRIT_UNUSED};
        write_reg(REG_REF_C0, 16'h8000);
        write_reg(REG_REF_C1, 16'h8000);
        write_reg(REG_REF_C2, 16'h8000);
        write_reg(REG_THRESHOLD, 16'h1000);
        write_reg(REG_OPTIONS, 16'h0000);
        write_reg(REG_CHANNELS, 16'd3);
        foreach (crit_list[k]) begin
            write_reg(REG_CRITERION, 16'(crit_list[k]));
            send_pixel(16'h8800, 16'h9800, 16'h7000, 16'h0000);
            wait_mask_drain();
        end
        write_reg(REG_CRITERION, 16'(CRIT_COMPOSITE));
        write_reg(REG_CHANNELS, 16'd0);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        wait_mask_drain();
        write_reg(REG_CHANNELS, 16'd3);
    endtask

    // Hue distance wraps around full scale
    task automatic test_hue_wrap();
        write_reg(REG_CRITERION, 16'(CRIT_HUE));
        write_reg(REG_REF_C0, 16'h0010);
        write_reg(REG_THRESHOLD, 16'h001F);
        send_pixel(16'hFFF0, 16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0030, 16'hFFFF, 16'h0000, 16'h0000);
        wait_mask_drain();
    endtask

    // Transparent pixels, transparent selection, and alpha ignored without it
    task automatic test_alpha_modes();
        write_reg(REG_CRITERION, 16'(CRIT_COMPOSITE));
        write_reg(REG_REF_C0, 16'h4000);
        write_reg(REG_THRESHOLD, 16'h0100);
        write_reg(REG_OPTIONS, 16'(1 << OPT_HAS_ALPHA));
        send_pixel(16'h4000, 16'h8000, 16'h8000, 16'h0000);
        send_pixel(16'h4000, 16'h8000, 16'h8000, 16'h0001);
        wait_mask_drain();
        write_reg(REG_REF_ALPHA, 16'h0000);
        write_reg(REG_OPTIONS, 16'((1 << OPT_HAS_ALPHA) | (1 << OPT_TRANSP)));
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0100);
        send_pixel(16'h4000, 16'h8000, 16'h8000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        wait_mask_drain();
        write_reg(REG_OPTIONS, 16'(1 << OPT_TRANSP));
        send_pixel(16'h4000, 16'h8000, 16'h8000, 16'h0000);
        wait_mask_drain();
        write_reg(REG_REF_ALPHA, 16'hFFFF);
    endtask

    // Antialias ramp edges, zero threshold, and full-scale threshold
    task automatic test_ramp();
        write_reg(REG_CRITERION, 16'(CRIT_RED));
        write_reg(REG_REF_C0, 16'h1000);
        write_reg(REG_THRESHOLD, 16'h0100);
        write_reg(REG_OPTIONS, 16'(1 << OPT_ANTIALIAS));
        send_pixel(16'h1100, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h1101, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h0E81, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h1180, 16'h0000, 16'h0000, 16'h0000);
        wait_mask_drain();
        write_reg(REG_THRESHOLD, 16'h0000);
        send_pixel(16'h1000, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h1001, 16'h0000, 16'h0000, 16'h0000);
        wait_mask_drain();
        write_reg(REG_REF_C0, 16'h0000);
        write_reg(REG_THRESHOLD, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        wait_mask_drain();
    endtask

    // Hold the output off while the sender keeps offering, to fill the pipe
    task automatic test_backpressure();
        @(posedge i_clk);
        holdoff_req   = ~holdoff_req;
        sender_steady = 1'b1;
        repeat (64)
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        wait_mask_drain();
        sender_steady = 1'b0;
    endtask

    // Pick a value near a center, spread by the threshold, an extreme, or a random value
    function automatic logic [CH_W-1:0] near_value(input logic [CH_W-1:0] center,
                                                   input logic [CH_W-1:0] thr);
        int span;
        int v;
        span = (int'(thr) * 7) / 2 + 4;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CH_FS;
            2, 3:    return CH_W'($urandom);
            default: begin
                v = int'(center) + int'($urandom_range(0, span)) - span / 2;
                if (v < 0) v = 0;
                if (v > int'(CH_FS)) v = int'(CH_FS);
                return CH_W'(v);
            end
        endcase
    endfunction

    // Random setups, each followed by pixels around its reference color
    task automatic test_random_setups();
        logic [CH_W-1:0] thr;
        logic [CH_W-1:0] ref_alpha;
        for (int setup = 0; setup < RANDOM_SETUPS; setup++) begin
            case (setup)
                0:       thr = '0;
                1:       thr = CH_FS;
                default: begin
                    case ($urandom_range(0, 5))
                        0:       thr = '0;
                        1:       thr = CH_FS;
                        2, 3:    thr = CH_W'($urandom_range(1, 16'h03FF));
                        default: thr = CH_W'($urandom);
                    endcase
                end
            endcase
            ref_alpha = ($urandom_range(0, 2) == 0) ? '0 : CH_W'($urandom);
            write_reg(REG_REF_C0, CH_W'($urandom));
            write_reg(REG_REF_C1, CH_W'($urandom));
            write_reg(REG_REF_C2, CH_W'($urandom));
            write_reg(REG_REF_ALPHA, ref_alpha);
            write_reg(REG_THRESHOLD, thr);
            // Set random upper bits on the narrow registers; they must be dropped
            write_reg(REG_CRITERION, {13'($urandom), 3'((setup * 3) % 8)});
            write_reg(REG_CHANNELS, {14'($urandom), 2'($urandom_range(0, 3))});
            write_reg(REG_OPTIONS, {13'($urandom),
                                    (setup < 8) ? 3'(setup) : 3'($urandom_range(0, 7))});
            sender_steady = ((setup % 4) == 3);
            repeat (PIXELS_PER_SETUP)
                send_pixel(near_value(cfg_model.ref_c0, thr),
                           near_value(cfg_model.ref_c1, thr),
                           near_value(cfg_model.ref_c2, thr),
                           near_value(cfg_model.ref_alpha, thr));
            wait_mask_drain();
            sender_steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_pix_c0    = '0;
        i_pix_c1    = '0;
        i_pix_c2    = '0;
        i_pix_alpha = '0;
        cfg_model   = '{ref_c0: '0, ref_c1: '0, ref_c2: '0, ref_alpha: CH_FS,
                        threshold: '0, criterion: CRIT_COMPOSITE, channels: 2'd3,
                        options: 3'd0};

        // Hold reset, then release it on a falling clock edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_criteria();
        test_hue_wrap();
        test_alpha_modes();
        test_ramp();
        test_backpressure();
        test_random_setups();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && mask_expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
